>>> rtl/bounded_ordered_list_engine_core_assert.svh
// assertion macros for the ordered list engine
// expects i_clk and i_rst_n in the scope of use
`ifndef BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define BOLE_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bole_pkg.sv
// shared types and constants of the ordered list engine
// no dependencies
package bole_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int VALUE_W      = 32;
    localparam int POS_W        = 4;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 3;
    localparam int COUNT_W      = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 2'd0,
        OP_APPEND    = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_READ      = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADIDX   = 3'd3,
        ST_NOTFOUND = 3'd4
    } t_status;

    typedef struct packed {
        logic                       go;
        t_op                        op;
        logic signed [VALUE_W-1:0]  value;
        logic                       full;
    } t_row_cmd;

    typedef struct packed {
        logic front_hit;
        logic back_hit;
        logic mid_hit;
    } t_row_hits;

endpackage

>>> rtl/bole_req_if.sv
// request channel of the ordered list engine
// depends on bole_pkg
interface bole_req_if;
    logic                                    valid;
    logic                                    ready;
    logic [bole_pkg::OP_W-1:0]               operation;
    logic signed [bole_pkg::VALUE_W-1:0]     item_value;
    logic [bole_pkg::POS_W-1:0]              position;

    modport source (output valid, output operation, output item_value, output position,
                    input ready);
    modport sink   (input valid, input operation, input item_value, input position,
                    output ready);
endinterface

>>> rtl/bole_rsp_if.sv
// response channel of the ordered list engine
// depends on bole_pkg
interface bole_rsp_if;
    logic                                    valid;
    logic                                    ready;
    logic [bole_pkg::STATUS_W-1:0]           status;
    logic signed [bole_pkg::VALUE_W-1:0]     read_value;
    logic [bole_pkg::COUNT_W-1:0]            entry_count;
    logic signed [bole_pkg::VALUE_W-1:0]     front_value;
    logic signed [bole_pkg::VALUE_W-1:0]     back_value;
    logic                                    list_empty;

    modport source (output valid, output status, output read_value, output entry_count,
                    output front_value, output back_value, output list_empty,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    input front_value, input back_value, input list_empty,
                    output ready);
endinterface

>>> rtl/bounded_ordered_list_engine_core.sv
// top level of the bounded ordered list engine: control, entry count, response register
// depends on bole_pkg, bole_req_if, bole_rsp_if, bole_row and the assertion header
//
//  channel   direction  beat holds
//  i_req     in         operation, item_value, position
//  o_rsp     out        status, read_value, entry_count, front_value, back_value, list_empty
//
// a request beat updates the cell row in the cycle it is taken; the response is
// formed in the report step from the row taps; no new request is taken until it is formed
// a request is taken while an earlier response still waits in the output register
// a waiting response holds the row in its reporting step until o_rsp is taken
// reset empties the list at once; the cells themselves are not cleared
`include "bounded_ordered_list_engine_core_assert.svh"

module bounded_ordered_list_engine_core #(
    parameter int P_CAPACITY = bole_pkg::DEF_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bole_req_if.sink   i_req,
    bole_rsp_if.source o_rsp
);
    localparam int CNT_W = $clog2(P_CAPACITY+1);
    localparam int CMP_W = (CNT_W > bole_pkg::POS_W) ? CNT_W : bole_pkg::POS_W;

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_REPORT = 2'b10
    } t_state;

    t_state                               r_state;
    t_state                               n_state;
    logic [CNT_W-1:0]                     r_count;
    logic [CNT_W-1:0]                     n_count;
    bole_pkg::t_status                    r_status;
    bole_pkg::t_status                    n_status;
    logic                                 r_is_read;
    logic [bole_pkg::POS_W-1:0]           r_pos;
    logic                                 r_out_valid;
    bole_pkg::t_status                    r_out_status;
    logic signed [bole_pkg::VALUE_W-1:0]  r_out_read;
    logic [bole_pkg::COUNT_W-1:0]         r_out_count;
    logic signed [bole_pkg::VALUE_W-1:0]  r_out_front;
    logic signed [bole_pkg::VALUE_W-1:0]  r_out_back;
    logic                                 r_out_empty;

    bole_pkg::t_row_cmd                   row_cmd;
    bole_pkg::t_row_hits                  row_hits;
    logic signed [bole_pkg::VALUE_W-1:0]  row_front;
    logic signed [bole_pkg::VALUE_W-1:0]  row_back;
    logic signed [bole_pkg::VALUE_W-1:0]  row_read;
    logic [bole_pkg::POS_W-1:0]           row_pos;
    bole_pkg::t_op                        req_op;
    logic                                 accept;
    logic                                 full;
    logic                                 empty;
    logic                                 report;

    assign accept = i_req.valid && i_req.ready;
    assign req_op = bole_pkg::t_op'(i_req.operation);
    assign full   = (r_count == CNT_W'(P_CAPACITY));
    assign empty  = (r_count == '0);
    assign report = (r_state == S_REPORT) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready = i_rst_n && (r_state == S_IDLE);

    assign row_cmd.go    = accept;
    assign row_cmd.op    = req_op;
    assign row_cmd.value = i_req.item_value;
    assign row_cmd.full  = full;
    assign row_pos       = (r_state == S_IDLE) ? i_req.position : r_pos;

    bole_row #(
        .P_CAPACITY(P_CAPACITY)
    ) u_row (
        .i_clk  (i_clk),
        .i_cmd  (row_cmd),
        .i_count(r_count),
        .i_pos  (row_pos),
        .o_hits (row_hits),
        .o_front(row_front),
        .o_back (row_back),
        .o_read (row_read)
    );

    always_comb begin
        n_count  = r_count;
        n_status = bole_pkg::ST_OK;
        case (req_op)
            bole_pkg::OP_INS_FRONT, bole_pkg::OP_APPEND: begin
                if (full) begin
                    n_status = bole_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            bole_pkg::OP_REMOVE: begin
                if (empty) begin
                    n_status = bole_pkg::ST_EMPTY;
                end else if (row_hits.front_hit || row_hits.back_hit || row_hits.mid_hit) begin
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = bole_pkg::ST_NOTFOUND;
                end
            end
            bole_pkg::OP_READ: begin
                if (empty) begin
                    n_status = bole_pkg::ST_EMPTY;
                end else if (CMP_W'(i_req.position) >= CMP_W'(r_count)) begin
                    n_status = bole_pkg::ST_BADIDX;
                end
            end
            default: begin
                n_status = bole_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (report) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_count <= n_count;
            end
            if (report) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= n_status;
            r_is_read <= (req_op == bole_pkg::OP_READ);
            r_pos     <= i_req.position;
        end
        if (report) begin
            r_out_status <= r_status;
            r_out_read   <= (r_is_read && (r_status == bole_pkg::ST_OK)) ? row_read : '0;
            r_out_count  <= bole_pkg::COUNT_W'(r_count);
            r_out_front  <= empty ? '0 : row_front;
            r_out_back   <= empty ? '0 : row_back;
            r_out_empty  <= empty;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.read_value  = r_out_read;
    assign o_rsp.entry_count = r_out_count;
    assign o_rsp.front_value = r_out_front;
    assign o_rsp.back_value  = r_out_back;
    assign o_rsp.list_empty  = r_out_empty;

    `BOLE_ASSERT_ALWAYS(a_count_bound, r_count <= CNT_W'(P_CAPACITY), "entry count over capacity")
    `BOLE_ASSERT_NEXT(a_accept_report, accept, r_state == S_REPORT, "beat taken without report")
    `BOLE_ASSERT_NEXT(a_count_hold, !accept, $stable(r_count), "entry count moved without a beat")
endmodule

>>> rtl/bole_cell.sv
// one list slot: holds an entry, compares it and shifts with its neighbours
// depends on bole_pkg
module bole_cell #(
    parameter int P_CAPACITY = bole_pkg::DEF_CAPACITY,
    parameter int P_INDEX    = 0
) (
    input  logic                                  i_clk,
    input  bole_pkg::t_row_cmd                    i_cmd,
    input  logic [$clog2(P_CAPACITY+1)-1:0]       i_count,
    input  logic [bole_pkg::POS_W-1:0]            i_pos,
    input  logic                                  i_front_hit,
    input  logic                                  i_back_hit,
    input  logic signed [bole_pkg::VALUE_W-1:0]   i_prev_entry,
    input  logic signed [bole_pkg::VALUE_W-1:0]   i_next_entry,
    input  logic                                  i_seen,
    output logic                                  o_seen,
    output logic                                  o_match,
    output logic                                  o_back_hit,
    output logic signed [bole_pkg::VALUE_W-1:0]   o_entry,
    output logic signed [bole_pkg::VALUE_W-1:0]   o_back_tap,
    output logic signed [bole_pkg::VALUE_W-1:0]   o_read_tap
);
    localparam int CNT_W = $clog2(P_CAPACITY+1);

    logic signed [bole_pkg::VALUE_W-1:0] r_entry;
    logic signed [bole_pkg::VALUE_W-1:0] n_entry;
    logic is_last;
    logic is_mid;
    logic mid_hit;
    logic take_prev;
    logic take_next;
    logic take_val;

    assign o_match    = (r_entry == i_cmd.value);
    assign is_last    = (i_count == CNT_W'(P_INDEX + 1));
    assign is_mid     = (P_INDEX >= 1) && (i_count > CNT_W'(P_INDEX + 1));
    assign mid_hit    = o_match && is_mid;
    assign o_seen     = i_seen || mid_hit;
    assign o_back_hit = o_match && is_last;
    assign o_entry    = r_entry;
    assign o_back_tap = is_last ? r_entry : '0;
    assign o_read_tap = ((P_INDEX < (1 << bole_pkg::POS_W))
                        && (i_pos == bole_pkg::POS_W'(P_INDEX))) ? r_entry : '0;

    assign take_prev = i_cmd.go && (i_cmd.op == bole_pkg::OP_INS_FRONT) && !i_cmd.full;
    assign take_val  = i_cmd.go && (i_cmd.op == bole_pkg::OP_APPEND) && !i_cmd.full
                       && (i_count == CNT_W'(P_INDEX));
    assign take_next = i_cmd.go && (i_cmd.op == bole_pkg::OP_REMOVE) && (i_count != '0)
                       && (i_front_hit || (!i_back_hit && o_seen));

    always_comb begin
        n_entry = r_entry;
        if (take_prev) begin
            n_entry = i_prev_entry;
        end else if (take_val) begin
            n_entry = i_cmd.value;
        end else if (take_next) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end
endmodule

>>> rtl/bole_row.sv
// row of list cells with the first-match chain and the read and back taps
// depends on bole_pkg and bole_cell
module bole_row #(
    parameter int P_CAPACITY = bole_pkg::DEF_CAPACITY
) (
    input  logic                                  i_clk,
    input  bole_pkg::t_row_cmd                    i_cmd,
    input  logic [$clog2(P_CAPACITY+1)-1:0]       i_count,
    input  logic [bole_pkg::POS_W-1:0]            i_pos,
    output bole_pkg::t_row_hits                   o_hits,
    output logic signed [bole_pkg::VALUE_W-1:0]   o_front,
    output logic signed [bole_pkg::VALUE_W-1:0]   o_back,
    output logic signed [bole_pkg::VALUE_W-1:0]   o_read
);
    logic signed [bole_pkg::VALUE_W-1:0] entry    [P_CAPACITY];
    logic signed [bole_pkg::VALUE_W-1:0] back_tap [P_CAPACITY];
    logic signed [bole_pkg::VALUE_W-1:0] read_tap [P_CAPACITY];
    logic [P_CAPACITY:0]                 seen;
    logic [P_CAPACITY-1:0]               match;
    logic [P_CAPACITY-1:0]               back_hit;

    assign seen[0] = 1'b0;

    for (genvar k = 0; k < P_CAPACITY; k++) begin : g_cell
        logic signed [bole_pkg::VALUE_W-1:0] prev_entry;
        logic signed [bole_pkg::VALUE_W-1:0] next_entry;

        if (k == 0) begin : g_first
            assign prev_entry = i_cmd.value;
        end else begin : g_inner
            assign prev_entry = entry[k-1];
        end
        if (k == P_CAPACITY - 1) begin : g_last
            assign next_entry = entry[k];
        end else begin : g_body
            assign next_entry = entry[k+1];
        end

        bole_cell #(
            .P_CAPACITY(P_CAPACITY),
            .P_INDEX   (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (i_cmd),
            .i_count     (i_count),
            .i_pos       (i_pos),
            .i_front_hit (o_hits.front_hit),
            .i_back_hit  (o_hits.back_hit),
            .i_prev_entry(prev_entry),
            .i_next_entry(next_entry),
            .i_seen      (seen[k]),
            .o_seen      (seen[k+1]),
            .o_match     (match[k]),
            .o_back_hit  (back_hit[k]),
            .o_entry     (entry[k]),
            .o_back_tap  (back_tap[k]),
            .o_read_tap  (read_tap[k])
        );
    end

    assign o_hits.front_hit = match[0];
    assign o_hits.back_hit  = |back_hit;
    assign o_hits.mid_hit   = seen[P_CAPACITY];
    assign o_front          = entry[0];

    always_comb begin
        o_back = '0;
        o_read = '0;
        for (int k = 0; k < P_CAPACITY; k++) begin
            o_back = o_back | back_tap[k];
            o_read = o_read | read_tap[k];
        end
    end
endmodule

>>> bench/bounded_ordered_list_engine_core_test.sv
// self-checking bench for the bounded ordered list engine: directed corner cases, a fill and drain,
// then random insert, append, remove and read traffic with a transaction-level predictor and idling
// depends on bole_pkg, bole_req_if, bole_rsp_if and the engine core
module bounded_ordered_list_engine_core_test;
    import bole_pkg::*;

    localparam int CAP           = DEF_CAPACITY;
    localparam int RUN_LIMIT     = 100000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        t_status                   status;
        logic signed [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [VALUE_W-1:0] front_value;
        logic signed [VALUE_W-1:0] back_value;
        logic                      list_empty;
    } list_result_t;

    logic i_clk;
    logic i_rst_n;

    bole_req_if req_ch ();
    bole_rsp_if rsp_ch ();

    bounded_ordered_list_engine_core #(.P_CAPACITY(CAP)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    logic signed [VALUE_W-1:0] list_mem [CAP];
    int                        list_len = 0;
    logic signed [VALUE_W-1:0] value_pool [8];
    list_result_t              awaited_results [$];
    list_result_t              due_result;
    int                        idle_pct = 9;
    int                        mismatches = 0;
    int                        beats_sent = 0;
    int                        beats_checked = 0;
    int                        status_tally [5] = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        repeat (RUN_LIMIT) @(posedge i_clk);
        $display("bounded_ordered_list_engine_core test failed");
        $finish;
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_ch.ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    function automatic list_result_t apply_op(t_op op, logic signed [VALUE_W-1:0] value,
                                              logic [POS_W-1:0] pos);
        list_result_t r;
        int hit;
        r.status     = ST_OK;
        r.read_value = '0;
        case (op)
            OP_INS_FRONT, OP_APPEND: begin
                if (list_len >= CAP) begin
                    r.status = ST_FULL;
                end else if (op == OP_APPEND) begin
                    list_mem[list_len] = value;
                    list_len++;
                end else begin
                    for (int k = list_len; k > 0; k--) list_mem[k] = list_mem[k-1];
                    list_mem[0] = value;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                hit = -1;
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // head first, then tail, then the first match in between
                    if (list_mem[0] == value) hit = 0;
                    else if (list_mem[list_len-1] == value) hit = list_len - 1;
                    else begin
                        for (int k = 1; k + 1 < list_len; k++)
                            if (hit < 0 && list_mem[k] == value) hit = k;
                    end
                    if (hit < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        for (int k = hit; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                        list_len--;
                    end
                end
            end
            default: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else if (int'(pos) >= list_len) r.status = ST_BADIDX;
                else r.read_value = list_mem[pos];
            end
        endcase
        r.entry_count = COUNT_W'(list_len);
        r.front_value = (list_len != 0) ? list_mem[0] : '0;
        r.back_value  = (list_len != 0) ? list_mem[list_len-1] : '0;
        r.list_empty  = (list_len == 0);
        status_tally[r.status]++;
        return r;
    endfunction

    function automatic void check_field(string name, logic signed [63:0] expv,
                                        logic signed [63:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0d, got %0d", name, expv, actv);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (awaited_results.size() == 0) begin
                $error("response beat with no request outstanding");
                mismatches++;
            end else begin
                due_result = awaited_results.pop_front();
                check_field("status", due_result.status, rsp_ch.status);
                check_field("read_value", due_result.read_value, rsp_ch.read_value);
                check_field("entry_count", due_result.entry_count, rsp_ch.entry_count);
                check_field("front_value", due_result.front_value, rsp_ch.front_value);
                check_field("back_value", due_result.back_value, rsp_ch.back_value);
                check_field("list_empty", due_result.list_empty, rsp_ch.list_empty);
                beats_checked++;
            end
        end
    end

    task automatic send_beat(t_op op, logic signed [VALUE_W-1:0] value, logic [POS_W-1:0] pos);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= op;
        req_ch.item_value <= value;
        req_ch.position   <= pos;
        do @(posedge i_clk); while (!req_ch.ready);
        awaited_results.push_back(apply_op(op, value, pos));
        beats_sent++;
    endtask

    task automatic hold_off();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(int pool_pct);
        if ($urandom_range(99) < pool_pct) return value_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic logic signed [VALUE_W-1:0] removal_value();
        if (list_len > 0 && $urandom_range(99) < 75) return list_mem[$urandom_range(list_len-1)];
        return pick_value(50);
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        if (list_len > 0 && $urandom_range(99) < 60) return POS_W'($urandom_range(list_len-1));
        return POS_W'($urandom_range(15));
    endfunction

    task automatic test_directed();
        send_beat(OP_READ, '0, 4'd0);
        send_beat(OP_REMOVE, 32'sd5, 4'd0);
        send_beat(OP_INS_FRONT, 32'sh7fffffff, 4'd0);
        send_beat(OP_APPEND, 32'sh80000000, 4'd15);
        send_beat(OP_INS_FRONT, 32'sd0, 4'd0);
        send_beat(OP_APPEND, -32'sd1, 4'd0);
        send_beat(OP_READ, '0, 4'd0);
        send_beat(OP_READ, '1, 4'd3);
        send_beat(OP_READ, '0, 4'd4);
        send_beat(OP_READ, '0, 4'd15);
        send_beat(OP_APPEND, 32'sd7, 4'd0);
        send_beat(OP_INS_FRONT, 32'sd7, 4'd0);
        send_beat(OP_REMOVE, 32'sd7, 4'd0);
        send_beat(OP_REMOVE, 32'sd7, 4'd0);
        send_beat(OP_REMOVE, 32'sh80000000, 4'd0);
        send_beat(OP_REMOVE, 32'sd123, 4'd0);
        send_beat(OP_APPEND, 32'sh7fffffff, 4'd0);
        // same value in the middle and at the back: the back one goes
        send_beat(OP_REMOVE, 32'sh7fffffff, 4'd0);
        send_beat(OP_READ, '0, 4'd1);
        send_beat(OP_REMOVE, -32'sd1, 4'd0);
        send_beat(OP_REMOVE, 32'sd0, 4'd0);
        send_beat(OP_REMOVE, 32'sh7fffffff, 4'd0);
        send_beat(OP_READ, '0, 4'd2);
    endtask

    task automatic test_fill_and_drain();
        while (list_len < CAP)
            send_beat($urandom_range(1) ? OP_INS_FRONT : OP_APPEND, $urandom,
                      POS_W'($urandom_range(15)));
        send_beat(OP_INS_FRONT, $urandom, 4'd0);
        send_beat(OP_APPEND, $urandom, 4'd0);
        for (int p = 0; p < CAP; p++) send_beat(OP_READ, $urandom, POS_W'(p));
        send_beat(OP_REMOVE, $urandom, 4'd0);
        while (list_len > 0)
            send_beat(OP_REMOVE, list_mem[$urandom_range(list_len-1)],
                      POS_W'($urandom_range(15)));
    endtask

    task automatic test_random_walk(int n_items, int pool_pct);
        int target;
        int r;
        t_op op;
        for (int k = 0; k < 8; k++) value_pool[k] = $urandom;
        target = $urandom_range(CAP);
        for (int i = 0; i < n_items; i++) begin
            if (i % 20 == 0) target = $urandom_range(CAP);
            r = $urandom_range(99);
            // drift towards a moving fill level so full and empty are both visited
            if (r < 25) op = OP_READ;
            else if ((list_len < target) == (r < 80))
                op = $urandom_range(1) ? OP_INS_FRONT : OP_APPEND;
            else op = OP_REMOVE;
            send_beat(op, (op == OP_REMOVE) ? removal_value() : pick_value(pool_pct),
                      pick_position());
        end
    endtask

    initial begin
        req_ch.valid      = 1'b0;
        req_ch.operation  = OP_INS_FRONT;
        req_ch.item_value = '0;
        req_ch.position   = '0;
        i_rst_n           = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        hold_off();
        test_fill_and_drain();
        test_random_walk(250, 50);
        hold_off();
        idle_pct = 0;
        test_random_walk(150, 20);
        idle_pct = 9;
        test_random_walk(120, 85);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d request beats and %0d checked response beats",
                 beats_sent, beats_checked);
        $display("outcomes: ok %0d, full %0d, empty %0d, bad index %0d, not found %0d",
                 status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
                 status_tally[ST_BADIDX], status_tally[ST_NOTFOUND]);
        if (mismatches == 0) begin
            $display("bounded_ordered_list_engine_core test passed");
        end else begin
            $display("bounded_ordered_list_engine_core test failed");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/bole_pkg.sv
rtl/bole_req_if.sv
rtl/bole_rsp_if.sv
rtl/bole_cell.sv
rtl/bole_row.sv
rtl/bounded_ordered_list_engine_core.sv
bench/bounded_ordered_list_engine_core_test.sv
